### rtl/core/csp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csp_pkg
// Types, constants and helper functions shared by the colour string parser.
// ----------------------------------------------------------------------------
package csp_pkg;

    localparam int MAX_TEXT   = 64;
    localparam int POS_W      = $clog2(MAX_TEXT + 5);
    localparam int NUM_NAMES  = 18;
    localparam int NAME_CHARS = 9;
    localparam int NAME_W     = 8 * NAME_CHARS;
    localparam int NUM_COMP   = 3;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_R     = 8'h72;

    typedef enum logic [5:0] {
        F_START    = 6'b000001,
        F_HEX      = 6'b000010,
        F_PREFIX   = 6'b000100,
        F_NAME     = 6'b001000,
        F_RGB      = 6'b010000,
        F_RGB_DONE = 6'b100000
    } form_t;

    typedef struct packed {
        form_t                             form;
        logic [POS_W-1:0]                  pos;
        logic [NUM_NAMES-1:0]              cand;
        logic [1:0]                        comp_idx;
        logic [2:0]                        first_len;
        logic [2:0]                        cur_len;
        logic [NUM_COMP-1:0][15:0]         comp;
        logic                              failed;
        logic [23:0]                       hex_acc;
        logic                              stopped;
    } parse_state_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } colour_res_t;

    typedef struct packed {
        logic [NAME_W-1:0] text;
        logic [3:0]        len;
        logic [7:0]        r;
        logic [7:0]        g;
        logic [7:0]        b;
    } colour_entry_t;

    localparam parse_state_t ST_RESET = '{
        form:      F_START,
        pos:       '0,
        cand:      '1,
        comp_idx:  '0,
        first_len: '0,
        cur_len:   '0,
        comp:      '0,
        failed:    1'b0,
        hex_acc:   '0,
        stopped:   1'b0
    };

    // names padded with spaces on the right, first character in the top byte
    localparam colour_entry_t NAME_TABLE [NUM_NAMES] = '{
        '{"black    ", 4'd5, 8'h00, 8'h00, 8'h00},
        '{"red      ", 4'd3, 8'hff, 8'h00, 8'h00},
        '{"green    ", 4'd5, 8'h00, 8'hff, 8'h00},
        '{"yellow   ", 4'd6, 8'hff, 8'hff, 8'h00},
        '{"blue     ", 4'd4, 8'h00, 8'h00, 8'hff},
        '{"magenta  ", 4'd7, 8'hff, 8'h00, 8'hff},
        '{"cyan     ", 4'd4, 8'h00, 8'hff, 8'hff},
        '{"white    ", 4'd5, 8'hff, 8'hff, 8'hff},
        '{"gray     ", 4'd4, 8'h80, 8'h80, 8'h80},
        '{"grey     ", 4'd4, 8'h80, 8'h80, 8'h80},
        '{"darkgray ", 4'd8, 8'h40, 8'h40, 8'h40},
        '{"darkgrey ", 4'd8, 8'h40, 8'h40, 8'h40},
        '{"lightgray", 4'd9, 8'hc0, 8'hc0, 8'hc0},
        '{"lightgrey", 4'd9, 8'hc0, 8'hc0, 8'hc0},
        '{"orange   ", 4'd6, 8'hff, 8'ha5, 8'h00},
        '{"purple   ", 4'd6, 8'h80, 8'h00, 8'h80},
        '{"brown    ", 4'd5, 8'ha5, 8'h2a, 8'h2a},
        '{"pink     ", 4'd4, 8'hff, 8'hc0, 8'hcb}
    };

    function automatic logic [7:0] entry_char(colour_entry_t e, logic [POS_W-1:0] p);
        logic [7:0] c;
        c = 8'h00;
        if (p < POS_W'(NAME_CHARS))
        begin
            c = e.text[8 * (NAME_CHARS - 1 - int'(p)) +: 8];
        end
        return c;
    endfunction

    function automatic logic [7:0] prefix_char(logic [1:0] p);
        logic [7:0] c;
        unique case (p)
            2'd0:    c = 8'h72;
            2'd1:    c = 8'h67;
            2'd2:    c = 8'h62;
            default: c = 8'h3a;
        endcase
        return c;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_digit(logic [7:0] c);
        logic [7:0] t;
        logic [4:0] d;
        d = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            t = c - 8'h30;
            d = {1'b1, t[3:0]};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            t = c - 8'h57;
            d = {1'b1, t[3:0]};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            t = c - 8'h37;
            d = {1'b1, t[3:0]};
        end
        return d;
    endfunction

    function automatic parse_state_t close_component(parse_state_t s);
        parse_state_t t;
        t = s;
        if (s.comp_idx != 2'd3)
        begin
            if (s.comp_idx == 2'd0)
            begin
                t.first_len = s.cur_len;
            end
            else if (s.cur_len != s.first_len)
            begin
                t.failed = 1'b1;
            end
            if (s.cur_len > 3'd4)
            begin
                t.comp[s.comp_idx] = '0;
            end
            t.comp_idx = s.comp_idx + 2'd1;
            t.cur_len  = '0;
            if (t.comp_idx == 2'd3)
            begin
                t.form = F_RGB_DONE;
            end
        end
        return t;
    endfunction

endpackage
`default_nettype wire

### rtl/core/csp_char_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csp_char_if
// Character channel: one string byte and its end mark per item.
// ----------------------------------------------------------------------------
interface csp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_text;

    modport source (output valid, ch, end_of_text, input ready);
    modport sink   (input valid, ch, end_of_text, output ready);
endinterface
`default_nettype wire

### rtl/core/csp_colour_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csp_colour_if
// Colour result channel: valid flag and 16-bit red, green and blue per item.
// ----------------------------------------------------------------------------
interface csp_colour_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;

    modport source (output valid, ok, red, green, blue, input ready);
    modport sink   (input valid, ok, red, green, blue, output ready);
endinterface
`default_nettype wire

### rtl/core/color_spec_text_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// color_spec_text_parser_unit
// Colour string parser: #RGB, #RRGGBB, rgb:R/G/B and 18 colour names.
//
// chars  (sink):   one character item per cycle unless ready is low, end_of_text
//                  on the last one. a zero byte ends the string; later bytes
//                  up to the end mark are ignored.
// colour (source): one item per string, ok with red, green and blue; all
//                  channels are zero when ok is low.
// The result item is built as the final character leaves the input
// register, then held in the result register.
// Throughput: one character per cycle unless a final character is held,
// set by the combinational update between input register and parser state.
// While a result waits, characters of the next string keep flowing; only
// the next final character holds in the input register until the result
// register is taken. ready of chars then follows ready of colour.
// Reset: all parser state returns to the start of string, both registers
// empty. The state also returns to it after every result.
// ----------------------------------------------------------------------------
module color_spec_text_parser_unit (
    input  wire logic     clk,
    input  wire logic     rst_n,
    csp_char_if.sink      chars,
    csp_colour_if.source  colour
);
    import csp_pkg::*;

    logic         in_vld_reg;
    logic [7:0]   ch_reg;
    logic         eot_reg;
    parse_state_t st_reg;
    parse_state_t st_next;
    logic         out_vld_reg;
    colour_res_t  res_reg;
    colour_res_t  res_next;
    logic         res_free;
    logic         adv;

    csp_step u_step (
        .st      (st_reg),
        .ch      (ch_reg),
        .st_next (st_next)
    );

    csp_result u_result (
        .st  (st_next),
        .res (res_next)
    );

    assign res_free     = !out_vld_reg || colour.ready;
    assign adv          = in_vld_reg && (!eot_reg || res_free);
    assign chars.ready  = !in_vld_reg || adv;

    assign colour.valid = out_vld_reg;
    assign colour.ok    = res_reg.ok;
    assign colour.red   = res_reg.red;
    assign colour.green = res_reg.green;
    assign colour.blue  = res_reg.blue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            st_reg      <= ST_RESET;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (chars.ready)
                in_vld_reg <= chars.valid;
            if (adv)
                st_reg <= eot_reg ? ST_RESET : st_next;
            if (adv && eot_reg)
                out_vld_reg <= 1'b1;
            else if (colour.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            ch_reg  <= chars.ch;
            eot_reg <= chars.end_of_text;
        end
        if (adv && eot_reg)
            res_reg <= res_next;
    end

    // a new result only after a final character has left the input register
    a_res_from_eot: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(adv && eot_reg))
        else $error("result raised without a final character");

    // an invalid colour carries zero intensities
    a_zero_when_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !res_reg.ok |->
            res_reg.red == 16'h0 && res_reg.green == 16'h0 && res_reg.blue == 16'h0)
        else $error("invalid colour with nonzero intensity");

    // input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !chars.ready |-> in_vld_reg && eot_reg && out_vld_reg && !colour.ready)
        else $error("input stalled without a waiting result");

    // parser state is back at the start of string after each result
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        $past(adv && eot_reg) |-> st_reg == ST_RESET)
        else $error("parser state not cleared after result");

endmodule
`default_nettype wire

### rtl/core/csp_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csp_step
// Parser state update for one character: name filter, form tracking,
// hex and rgb component collection.
// ----------------------------------------------------------------------------
module csp_step (
    input  csp_pkg::parse_state_t st,
    input  logic [7:0]            ch,
    output csp_pkg::parse_state_t st_next
);
    import csp_pkg::*;

    logic [7:0] lc;
    logic [4:0] dig;

    assign lc  = (ch >= 8'h41 && ch <= 8'h5a) ? ch + 8'h20 : ch;
    assign dig = hex_digit(ch);

    always_comb
    begin
        st_next = st;
        if (!st.stopped)
        begin
            if (ch == 8'h00)
            begin
                st_next.stopped = 1'b1;
            end
            else
            begin
                for (int i = 0; i < NUM_NAMES; i++)
                begin
                    if (st.pos >= POS_W'(NAME_TABLE[i].len) ||
                        entry_char(NAME_TABLE[i], st.pos) != lc)
                    begin
                        st_next.cand[i] = 1'b0;
                    end
                end

                unique case (st.form)
                    F_START:
                    begin
                        if (ch == CH_HASH)
                            st_next.form = F_HEX;
                        else if (ch == CH_R)
                            st_next.form = F_PREFIX;
                        else
                            st_next.form = F_NAME;
                    end
                    F_PREFIX:
                    begin
                        if (st.pos < POS_W'(4) && ch == prefix_char(st.pos[1:0]))
                        begin
                            if (st.pos == POS_W'(3))
                                st_next.form = F_RGB;
                        end
                        else
                        begin
                            st_next.form = F_NAME;
                        end
                    end
                    F_HEX:
                    begin
                        if (!dig[4])
                            st_next.failed = 1'b1;
                        else
                            st_next.hex_acc = {st.hex_acc[19:0], dig[3:0]};
                    end
                    F_RGB:
                    begin
                        if (ch == CH_SLASH)
                        begin
                            if (st.cur_len != 3'd0)
                                st_next = close_component(st_next);
                        end
                        else
                        begin
                            if (!dig[4])
                                st_next.failed = 1'b1;
                            if (st.cur_len < 3'd5)
                                st_next.cur_len = st.cur_len + 3'd1;
                            if (st.comp_idx != 2'd3 && dig[4])
                                st_next.comp[st.comp_idx] =
                                    {st.comp[st.comp_idx][11:0], dig[3:0]};
                        end
                    end
                    F_NAME, F_RGB_DONE:
                    begin
                    end
                    default:
                    begin
                    end
                endcase

                if (st.pos != '1)
                    st_next.pos = st.pos + POS_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/csp_result.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csp_result
// End of string evaluation: checks the collected form and builds the
// 16-bit colour result.
// ----------------------------------------------------------------------------
module csp_result (
    input  csp_pkg::parse_state_t st,
    output csp_pkg::colour_res_t  res
);
    import csp_pkg::*;

    parse_state_t fin;
    logic         found;

    assign fin = (st.form == F_RGB && st.cur_len != 3'd0) ? close_component(st) : st;

    always_comb
    begin
        res   = '0;
        found = 1'b0;
        if (st.form == F_HEX)
        begin
            if (!st.failed && st.pos == POS_W'(4))
            begin
                res.ok    = 1'b1;
                res.red   = {4{st.hex_acc[11:8]}};
                res.green = {4{st.hex_acc[7:4]}};
                res.blue  = {4{st.hex_acc[3:0]}};
            end
            else if (!st.failed && st.pos == POS_W'(7))
            begin
                res.ok    = 1'b1;
                res.red   = {2{st.hex_acc[23:16]}};
                res.green = {2{st.hex_acc[15:8]}};
                res.blue  = {2{st.hex_acc[7:0]}};
            end
        end
        else if (st.form == F_RGB || st.form == F_RGB_DONE)
        begin
            if (!fin.failed && fin.comp_idx == 2'd3 &&
                (fin.first_len == 3'd2 || fin.first_len == 3'd4) &&
                fin.pos >= POS_W'(4) &&
                (fin.pos - POS_W'(4)) < POS_W'(MAX_TEXT))
            begin
                res.ok = 1'b1;
                if (fin.first_len == 3'd2)
                begin
                    res.red   = {2{fin.comp[0][7:0]}};
                    res.green = {2{fin.comp[1][7:0]}};
                    res.blue  = {2{fin.comp[2][7:0]}};
                end
                else
                begin
                    res.red   = fin.comp[0];
                    res.green = fin.comp[1];
                    res.blue  = fin.comp[2];
                end
            end
        end
        else
        begin
            for (int i = 0; i < NUM_NAMES; i++)
            begin
                if (!found && st.cand[i] && POS_W'(NAME_TABLE[i].len) == st.pos)
                begin
                    found     = 1'b1;
                    res.ok    = 1'b1;
                    res.red   = {2{NAME_TABLE[i].r}};
                    res.green = {2{NAME_TABLE[i].g}};
                    res.blue  = {2{NAME_TABLE[i].b}};
                end
            end
        end
    end

endmodule
`default_nettype wire
